### sv/phrd_pkg.sv
// Shared types and constants for the PCM halving and requantizing block.
// No dependencies.
package phrd_pkg;

   typedef enum logic [1:0] {
      MODE_REDUCE16     = 2'd0,
      MODE_HALVE_REDUCE = 2'd1,
      MODE_HALVE16      = 2'd2,
      MODE_HALVE8       = 2'd3
   } mode_type;

   localparam int SAMPLE_W = 16;
   localparam int ACC_W    = 21;   // accumulator, holds every biased value plus rounding half
   localparam int ERR_W    = 11;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   localparam logic [CSR_AW-1:0] CSR_MODE_ADDR = CSR_AW'(0);

   localparam logic signed [ACC_W-1:0] BIAS16   = ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] BIAS_SUM = ACC_W'(32768 * 4);

   localparam logic signed [ACC_W-1:0] HALF8    = ACC_W'(127);
   localparam logic signed [ACC_W-1:0] HALF10   = ACC_W'(512);
   localparam logic signed [ACC_W-1:0] HALF2    = ACC_W'(2);

   localparam logic [ACC_W-1:0] MASK8  = ACC_W'(32'hffffff00);
   localparam logic [ACC_W-1:0] MASK10 = ACC_W'(32'hfffffc00);
   localparam logic [ACC_W-1:0] MASK2  = ACC_W'(32'hfffffffc);

   localparam logic signed [ACC_W-1:0] TOP_REDUCE16 = ACC_W'(32'hff00);
   localparam logic signed [ACC_W-1:0] TOP_HALVE_RD = ACC_W'(32'h3fc00);
   localparam logic signed [ACC_W-1:0] TOP_HALVE16  = ACC_W'(32'h3fffc);
   localparam logic signed [ACC_W-1:0] TOP_HALVE8   = ACC_W'(32'h3fc);

   localparam logic signed [ACC_W:0] ERR_MAX = (ACC_W+1)'(1023);
   localparam logic signed [ACC_W:0] ERR_MIN = -(ACC_W+1)'(1024);

endpackage

### sv/pcm_halve_and_requantize_dither.sv
// PCM requantizer with error feedback and a 1-2-1 half-band decimator.
// Depends on phrd_pkg.
//
// Usage:
//   req_ channel carries one PCM word (req_sample_in, req_first); rsp_ channel
//   carries one result word (rsp_sample_out). A word moves when valid is high
//   and stall is low at a rising clock edge.
//   csr_ is an APB-style port with one register, mode, at address 0.
//   Mode 0 gives one result per input word; the halving modes give one result
//   for every second word of a pair, and a trailing odd word gives none.
//   Latency: a word is held in the input register and its result in the result
//   register, which drives rsp_. Throughput: one input word per cycle while rsp_ is
//   not stalled; the error feedback loop closes within the compute stage.
//   A stalled result register holds its word and stalls the compute stage,
//   which in turn stalls req_ once the input register is full.
//   Reset (synchronous) empties both registers, clears the filter and error
//   state and sets mode to 0.
module pcm_halve_and_requantize_dither (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [15:0]        req_sample_in,
   input  logic                      req_first,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [15:0]        rsp_sample_out,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [phrd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [phrd_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [phrd_pkg::CSR_DW-1:0] csr_prdata,
   output logic                      csr_pready
);
   import phrd_pkg::*;

   mode_type mode_ff;

   logic                       in_valid_ff;
   logic signed [SAMPLE_W-1:0] in_sample_ff;
   logic                       in_first_ff;

   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_W-1:0] held_ff, held_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic                       phase_ff, phase_in;

   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;

   logic                       advance;
   logic                       has_result;
   logic signed [SAMPLE_W-1:0] s_val, prev_eff;
   logic signed [ERR_W-1:0]    e_eff;
   logic                       phase_eff;
   logic signed [ACC_W-1:0]    filt, acc, half, top, rnd, rq;
   logic [ACC_W-1:0]           mask;
   logic signed [ACC_W:0]      diff;

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_MODE_ADDR) ? CSR_DW'(mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_REDUCE16;
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_MODE_ADDR)) begin
         mode_ff <= mode_type'(csr_pwdata[1:0]);
      end
   end

   // handshake
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;

   always_comb begin
      s_val     = (mode_ff == MODE_HALVE8) ? SAMPLE_W'({8'h00, in_sample_ff[7:0]})
                                           : in_sample_ff;
      e_eff     = in_first_ff ? '0 : err_ff;
      phase_eff = in_first_ff ? 1'b0 : phase_ff;
      prev_eff  = (in_first_ff && mode_ff != MODE_REDUCE16) ? s_val : prev_ff;

      filt = ACC_W'(prev_eff) + (ACC_W'(held_ff) <<< 1) + ACC_W'(s_val);

      unique case (mode_ff)
         MODE_REDUCE16: begin
            acc  = ACC_W'(e_eff) + ACC_W'(s_val) + BIAS16;
            half = HALF8;
            mask = MASK8;
            top  = TOP_REDUCE16;
         end
         MODE_HALVE_REDUCE: begin
            acc  = ACC_W'(e_eff) + BIAS_SUM + filt;
            half = HALF10;
            mask = MASK10;
            top  = TOP_HALVE_RD;
         end
         MODE_HALVE16: begin
            acc  = ACC_W'(e_eff) + BIAS_SUM + filt;
            half = HALF2;
            mask = MASK2;
            top  = TOP_HALVE16;
         end
         default: begin
            acc  = ACC_W'(e_eff) + filt;
            half = HALF2;
            mask = MASK2;
            top  = TOP_HALVE8;
         end
      endcase

      rnd = acc + half;
      if (rnd < 0) begin
         rq = '0;
      end else begin
         rq = $signed(rnd & mask);
         if (rq > top) begin
            rq = top;
         end
      end

      diff = (ACC_W+1)'(acc) - (ACC_W+1)'(rq);
      if (diff > ERR_MAX) begin
         diff = ERR_MAX;
      end else if (diff < ERR_MIN) begin
         diff = ERR_MIN;
      end

      unique case (mode_ff)
         MODE_REDUCE16:     out_sample_in = SAMPLE_W'({8'h00, rq[15:8]});
         MODE_HALVE_REDUCE: out_sample_in = SAMPLE_W'({8'h00, rq[17:10]});
         MODE_HALVE16:      out_sample_in = {~rq[17], rq[16:2]};
         default:           out_sample_in = SAMPLE_W'({8'h00, rq[9:2]});
      endcase

      has_result = (mode_ff == MODE_REDUCE16) || phase_eff;
      err_in     = has_result ? ERR_W'(diff) : e_eff;

      if (mode_ff == MODE_REDUCE16) begin
         phase_in = phase_eff;
         prev_in  = prev_eff;
         held_in  = held_ff;
      end else if (phase_eff) begin
         phase_in = 1'b0;
         prev_in  = s_val;
         held_in  = held_ff;
      end else begin
         phase_in = 1'b1;
         prev_in  = prev_eff;
         held_in  = s_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
         held_ff      <= '0;
         err_ff       <= '0;
         phase_ff     <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
            if (req_valid) begin
               in_sample_ff <= req_sample_in;
               in_first_ff  <= req_first;
            end
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff && has_result;
            if (in_valid_ff) begin
               prev_ff  <= prev_in;
               held_ff  <= held_in;
               err_ff   <= err_in;
               phase_ff <= phase_in;
               if (has_result) begin
                  out_sample_ff <= out_sample_in;
               end
            end
         end
      end
   end

endmodule

### bench/tb_top.sv
// Self-checking bench for pcm_halve_and_requantize_dither: directed and random PCM words
// in all four modes, checked against an in-bench requantizer and halving predictor.
// Depends on phrd_pkg and the block's RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import phrd_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SEG_WORDS   = 45;

   typedef struct {
      logic [15:0] smp;
      logic        first;
      logic        drain;
   } pcm_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic signed [15:0]        req_sample_in = '0;
   logic                      req_first     = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   logic signed [15:0]        rsp_sample_out;
   logic                      csr_psel      = 1'b0;
   logic                      csr_penable   = 1'b0;
   logic                      csr_pwrite    = 1'b0;
   logic [CSR_AW-1:0]         csr_paddr     = '0;
   logic [CSR_DW-1:0]         csr_pwdata    = '0;
   logic [CSR_DW-1:0]         csr_prdata;
   logic                      csr_pready;

   pcm_word_type pending_words[$];
   logic [15:0]  expected_out[$];

   // predictor state
   mode_type cur_mode  = MODE_REDUCE16;
   int       prev_smp  = 0;
   int       held_smp  = 0;
   int       err_fb    = 0;
   bit       phase_odd = 1'b0;

   int cyc          = 0;
   int failures     = 0;
   int send_idle_pct = 11;
   int recv_idle_pct = 58;

   pcm_halve_and_requantize_dither i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic int round_sat(int v, int half, int step, int top);
      int t;
      int r;
      t = v + half;
      if (t < 0) begin
         return 0;
      end
      r = t & ~(step - 1);
      return (r > top) ? top : r;
   endfunction

   function automatic void requantize_word(logic [15:0] smp, logic first);
      int          s;
      int          v;
      int          r;
      int          f;
      int          e;
      logic [15:0] res;
      bit          gives;
      s     = (cur_mode == MODE_HALVE8) ? int'(smp[7:0]) : int'($signed(smp));
      gives = 1'b1;
      v     = 0;
      r     = 0;
      res   = '0;
      if (first) begin
         err_fb    = 0;
         phase_odd = 1'b0;
         if (cur_mode != MODE_REDUCE16) begin
            prev_smp = s;
         end
      end
      if (cur_mode == MODE_REDUCE16) begin
         v   = err_fb + s + 32768;
         r   = round_sat(v, 127, 256, 'hff00);
         res = 16'(r >> 8);
      end else if (!phase_odd) begin
         held_smp  = s;
         phase_odd = 1'b1;
         gives     = 1'b0;
      end else begin
         f         = prev_smp + 2 * held_smp + s;
         prev_smp  = s;
         phase_odd = 1'b0;
         case (cur_mode)
            MODE_HALVE_REDUCE: begin
               v   = err_fb + 32768 * 4 + f;
               r   = round_sat(v, 512, 1024, 'h3fc00);
               res = 16'(r >> 10);
            end
            MODE_HALVE16: begin
               v   = err_fb + 32768 * 4 + f;
               r   = round_sat(v, 2, 4, 'h3fffc);
               res = 16'((r >> 2) - 32768);
            end
            default: begin
               v   = err_fb + f;
               r   = round_sat(v, 2, 4, 'h3fc);
               res = 16'(r >> 2);
            end
         endcase
      end
      if (gives) begin
         e = v - r;
         if (e > 1023) e = 1023;
         if (e < -1024) e = -1024;
         err_fb = e;
         expected_out.push_back(res);
      end
   endfunction

   function automatic bit idle_now(int pct);
      return $urandom_range(99) < pct;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("[%0d] mismatch: %s: got %h, expected %h", cyc, what, got, want);
      failures++;
   endtask

   always @(posedge clock) begin : driver
      pcm_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            requantize_word(req_sample_in, req_first);
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && !idle_now(send_idle_pct) &&
                !(pending_words[0].drain && expected_out.size() != 0)) begin
               w = pending_words.pop_front();
               req_valid     <= 1'b1;
               req_sample_in <= w.smp;
               req_first     <= w.first;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      logic [15:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_out.size() == 0) begin
               report_mismatch("word with nothing expected", rsp_sample_out, 'x);
            end else begin
               want = expected_out.pop_front();
               if (rsp_sample_out !== want) begin
                  report_mismatch("sample_out", rsp_sample_out, want);
               end
            end
         end
         rsp_stall <= idle_now(recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic add_word(logic [15:0] smp, logic first, logic drain = 1'b0);
      pcm_word_type w;
      w.smp   = smp;
      w.first = first;
      w.drain = drain;
      pending_words.push_back(w);
   endtask

   task automatic wait_quiet();
      while (pending_words.size() != 0 || req_valid || expected_out.size() != 0) begin
         @(posedge clock);
      end
      // an odd word may still be in the pipe with no result due
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(mode_type m);
      wait_quiet();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_MODE_ADDR;
      csr_pwdata  <= CSR_DW'(m);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_mode = m;
   endtask

   function automatic logic [15:0] rand_pcm();
      case ($urandom_range(15))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         4:       return {8'($urandom), 8'hff};
         5:       return {8'($urandom), 8'h00};
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int       n;
      int       len;
      mode_type m;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reduce 16 to 8: extremes, output clamping at the top on a run of full scale
      add_word(16'h8000, 1'b1);
      add_word(16'h7fff, 1'b0);
      add_word(16'h7fff, 1'b0);
      add_word(16'h7fff, 1'b0);
      add_word(16'h0000, 1'b0);
      add_word(16'hffff, 1'b0);
      add_word(16'h8000, 1'b0);

      // halve and reduce, ending on a trailing odd word
      write_mode(MODE_HALVE_REDUCE);
      add_word(16'h7fff, 1'b1);
      add_word(16'h7fff, 1'b0);
      add_word(16'h8000, 1'b0);
      add_word(16'h8000, 1'b0);
      add_word(16'd12345, 1'b0);

      // halve 16 mid-stream: pairs with the held odd word, ends with prev at minimum
      write_mode(MODE_HALVE16);
      add_word(16'h8000, 1'b0);
      add_word(16'd100, 1'b1);
      add_word(16'd200, 1'b0);
      add_word(16'h7fff, 1'b0);
      add_word(16'h7fff, 1'b0);
      add_word(16'h8000, 1'b0);
      add_word(16'h8000, 1'b0);

      // halve 8 mid-stream: negative sum rounds to zero, error clamps low
      write_mode(MODE_HALVE8);
      add_word(16'h0000, 1'b0);
      add_word(16'h0000, 1'b0);
      add_word(16'hff80, 1'b1);
      add_word(16'h12ff, 1'b0);
      add_word(16'hffff, 1'b0);
      add_word(16'hffff, 1'b0);

      for (int ph = 0; ph < 3; ph++) begin
         wait_quiet();
         send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 58 : 0;
         recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 11 : 0;
         for (int k = 0; k < 3; k++) begin
            m = mode_type'((3 * ph + k) % 4);
            write_mode(m);
            n = 0;
            while (n < SEG_WORDS) begin
               len = $urandom_range(14, 1);
               for (int j = 0; j < len && n < SEG_WORDS; j++) begin
                  add_word(rand_pcm(),
                           (j == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0),
                           (k == 1 && n == 20));
                  n++;
               end
            end
         end
      end

      wait_quiet();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### pcm_halve_and_requantize_dither.f
sv/phrd_pkg.sv
sv/pcm_halve_and_requantize_dither.sv
bench/tb_top.sv
